// File: rtl/core/ccf_pkg.sv
// ----------------------------------------------------------------------------
// ccf_pkg
// Shared widths, codes and stage payload types for the cube contact force
// pipeline.
// ----------------------------------------------------------------------------
package ccf_pkg;

    localparam int DEV_W    = 16;
    localparam int COEF_W   = 16;
    localparam int ROW_W    = 64;
    localparam int APP_W    = 16;
    localparam int PROD_W   = 32;
    localparam int OFS_W    = 31;
    localparam int ACC_W    = 34;
    localparam int APP_SH   = 15;
    localparam int H_W      = 16;
    localparam int P_W      = 17;
    localparam int DIST_W   = 19;
    localparam int MAG_W    = 18;
    localparam int STIFF_W  = 16;
    localparam int FPROD_W  = 36;
    localparam int FORCE_SH = 9;
    localparam int FORCE_W  = 24;
    localparam int FACE_W   = 3;
    localparam int ADDR_W   = 3;
    localparam int NUM_AXES = 3;
    localparam int NUM_FACES = 6;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 128;

    localparam logic [ADDR_W-1:0] REG_ROW_X     = 3'd0;
    localparam logic [ADDR_W-1:0] REG_ROW_Y     = 3'd1;
    localparam logic [ADDR_W-1:0] REG_ROW_Z     = 3'd2;
    localparam logic [ADDR_W-1:0] REG_EDGE_LEN  = 3'd3;
    localparam logic [ADDR_W-1:0] REG_STIFFNESS = 3'd4;
    localparam logic [ADDR_W-1:0] REG_ENABLE    = 3'd5;

    localparam logic [FACE_W-1:0] SIDE_NEAR   = 3'd0;
    localparam logic [FACE_W-1:0] SIDE_RIGHT  = 3'd1;
    localparam logic [FACE_W-1:0] SIDE_FAR    = 3'd2;
    localparam logic [FACE_W-1:0] SIDE_LEFT   = 3'd3;
    localparam logic [FACE_W-1:0] SIDE_TOP    = 3'd4;
    localparam logic [FACE_W-1:0] SIDE_BOTTOM = 3'd5;
    localparam logic [FACE_W-1:0] SIDE_NONE   = 3'd6;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [H_W-1:0]     EDGE_LEN_RST  = 16'd256;
    localparam logic [STIFF_W-1:0] STIFFNESS_RST = 16'd256;

    typedef struct packed {
        logic [NUM_AXES-1:0][ROW_W-1:0] rows;
        logic [H_W-1:0]                 edge_len;
        logic [STIFF_W-1:0]             stiffness;
        logic                           en;
    } cfg_t;

    typedef struct packed {
        logic                    valid;
        logic signed [APP_W-1:0] app_x;
        logic signed [APP_W-1:0] app_y;
        logic signed [APP_W-1:0] app_z;
    } app_item_t;

    typedef struct packed {
        logic                     valid;
        logic signed [APP_W-1:0]  app_x;
        logic signed [APP_W-1:0]  app_y;
        logic signed [APP_W-1:0]  app_z;
        logic signed [DIST_W-1:0] diff;
        logic [1:0]               axis;
        logic [FACE_W-1:0]        face;
    } face_item_t;

    typedef struct packed {
        logic                      valid;
        logic signed [APP_W-1:0]   app_x;
        logic signed [APP_W-1:0]   app_y;
        logic signed [APP_W-1:0]   app_z;
        logic signed [FORCE_W-1:0] force_x;
        logic signed [FORCE_W-1:0] force_y;
        logic signed [FORCE_W-1:0] force_z;
        logic [FACE_W-1:0]         face;
    } result_t;

endpackage

// File: rtl/core/ccf_affine.sv
// ----------------------------------------------------------------------------
// ccf_affine
// Two-stage affine map: nine products, then row sum, round and saturate.
// ----------------------------------------------------------------------------
module ccf_affine (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              adv,
    input  logic                              in_valid,
    input  logic signed [ccf_pkg::DEV_W-1:0]  dev_x,
    input  logic signed [ccf_pkg::DEV_W-1:0]  dev_y,
    input  logic signed [ccf_pkg::DEV_W-1:0]  dev_z,
    input  ccf_pkg::cfg_t                     cfg,
    output ccf_pkg::app_item_t                out
);

    localparam logic signed [ccf_pkg::ACC_W-1:0] HALF =
        ccf_pkg::ACC_W'(1) <<< (ccf_pkg::APP_SH - 1);
    localparam logic signed [ccf_pkg::ACC_W-1:0] APP_MAX = ccf_pkg::ACC_W'(32767);
    localparam logic signed [ccf_pkg::ACC_W-1:0] APP_MIN = -ccf_pkg::ACC_W'(32768);

    logic signed [ccf_pkg::DEV_W-1:0]  dev [ccf_pkg::NUM_AXES];
    logic signed [ccf_pkg::PROD_W-1:0] prod_reg [ccf_pkg::NUM_AXES][ccf_pkg::NUM_AXES];
    logic signed [ccf_pkg::OFS_W-1:0]  ofs_reg [ccf_pkg::NUM_AXES];
    logic                              v1_reg;
    logic signed [ccf_pkg::ACC_W-1:0]  acc [ccf_pkg::NUM_AXES];
    logic signed [ccf_pkg::ACC_W-1:0]  shf [ccf_pkg::NUM_AXES];
    logic signed [ccf_pkg::APP_W-1:0]  app_next [ccf_pkg::NUM_AXES];
    logic signed [ccf_pkg::APP_W-1:0]  app_reg [ccf_pkg::NUM_AXES];
    logic                              v2_reg;

    assign dev[0] = dev_x;
    assign dev[1] = dev_y;
    assign dev[2] = dev_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < ccf_pkg::NUM_AXES; r++) begin
                for (int c = 0; c < ccf_pkg::NUM_AXES; c++) begin
                    prod_reg[r][c] <=
                        signed'(cfg.rows[r][c*ccf_pkg::COEF_W +: ccf_pkg::COEF_W]) * dev[c];
                end
                ofs_reg[r] <= signed'({cfg.rows[r][ccf_pkg::ROW_W-1 -: ccf_pkg::COEF_W],
                                       {ccf_pkg::APP_SH{1'b0}}});
            end
        end
    end

    always_comb begin
        for (int r = 0; r < ccf_pkg::NUM_AXES; r++) begin
            acc[r] = ccf_pkg::ACC_W'(prod_reg[r][0]) + ccf_pkg::ACC_W'(prod_reg[r][1])
                   + ccf_pkg::ACC_W'(prod_reg[r][2]) + ccf_pkg::ACC_W'(ofs_reg[r]);
            shf[r] = (acc[r] + HALF) >>> ccf_pkg::APP_SH;
            if (shf[r] > APP_MAX) begin
                app_next[r] = 16'sh7FFF;
            end else if (shf[r] < APP_MIN) begin
                app_next[r] = 16'sh8000;
            end else begin
                app_next[r] = signed'(shf[r][ccf_pkg::APP_W-1:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < ccf_pkg::NUM_AXES; r++) begin
                app_reg[r] <= app_next[r];
            end
        end
    end

    assign out.valid = v2_reg;
    assign out.app_x = app_reg[0];
    assign out.app_y = app_reg[1];
    assign out.app_z = app_reg[2];

endmodule

// File: rtl/core/ccf_face.sv
// ----------------------------------------------------------------------------
// ccf_face
// Two-stage face search: face distances and extent tests, then nearest
// face select and spring displacement.
// ----------------------------------------------------------------------------
module ccf_face (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  ccf_pkg::app_item_t  in,
    input  ccf_pkg::cfg_t       cfg,
    output ccf_pkg::face_item_t out
);

    logic signed [ccf_pkg::P_W-1:0]    p [ccf_pkg::NUM_AXES];
    logic signed [ccf_pkg::DIST_W-1:0] h;
    logic signed [ccf_pkg::DIST_W-1:0] fdist [ccf_pkg::NUM_FACES];
    logic signed [ccf_pkg::DIST_W-1:0] pneg [ccf_pkg::NUM_AXES];
    logic signed [ccf_pkg::DIST_W-1:0] dist_reg [ccf_pkg::NUM_FACES];
    logic [ccf_pkg::MAG_W-1:0]         mag_reg [ccf_pkg::NUM_FACES];
    logic [ccf_pkg::NUM_AXES-1:0]      inb_next;
    logic [ccf_pkg::NUM_AXES-1:0]      inb_reg;
    ccf_pkg::app_item_t                app_reg;
    logic                              v3_reg;

    logic [ccf_pkg::FACE_W-1:0]        best;
    logic [ccf_pkg::MAG_W-1:0]         minm;
    logic [1:0]                        axis;
    logic                              in_ext;
    logic                              contact;
    logic signed [ccf_pkg::DIST_W-1:0] sel;
    logic signed [ccf_pkg::DIST_W-1:0] diff_next;

    ccf_pkg::face_item_t               out_reg;
    logic                              v4_reg;

    assign p[0] = signed'({in.app_x, 1'b0});
    assign p[1] = signed'({in.app_y, 1'b0});
    assign p[2] = signed'({in.app_z, 1'b0});
    assign h    = signed'(ccf_pkg::DIST_W'(cfg.edge_len));

    always_comb begin
        fdist[0] = h - ccf_pkg::DIST_W'(p[2]);
        fdist[1] = h - ccf_pkg::DIST_W'(p[0]);
        fdist[2] = ccf_pkg::DIST_W'(p[2]) + h;
        fdist[3] = ccf_pkg::DIST_W'(p[0]) + h;
        fdist[4] = h - ccf_pkg::DIST_W'(p[1]);
        fdist[5] = ccf_pkg::DIST_W'(p[1]) + h;
        for (int k = 0; k < ccf_pkg::NUM_AXES; k++) begin
            pneg[k] = p[k][ccf_pkg::P_W-1] ? -ccf_pkg::DIST_W'(p[k]) : ccf_pkg::DIST_W'(p[k]);
            inb_next[k] = pneg[k] < h;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= in.valid;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            app_reg <= in;
            inb_reg <= inb_next;
            for (int k = 0; k < ccf_pkg::NUM_FACES; k++) begin
                dist_reg[k] <= fdist[k];
                mag_reg[k]  <= fdist[k][ccf_pkg::DIST_W-1]
                             ? ccf_pkg::MAG_W'(-fdist[k]) : ccf_pkg::MAG_W'(fdist[k]);
            end
        end
    end

    always_comb begin
        best = ccf_pkg::SIDE_NEAR;
        minm = mag_reg[0];
        for (int k = 1; k < ccf_pkg::NUM_FACES; k++) begin
            if (mag_reg[k] < minm) begin
                best = ccf_pkg::FACE_W'(k);
                minm = mag_reg[k];
            end
        end
        sel = dist_reg[best];
        unique case (best)
            ccf_pkg::SIDE_NEAR, ccf_pkg::SIDE_FAR: begin
                axis   = ccf_pkg::AXIS_Z;
                in_ext = inb_reg[0] && inb_reg[1];
            end
            ccf_pkg::SIDE_RIGHT, ccf_pkg::SIDE_LEFT: begin
                axis   = ccf_pkg::AXIS_X;
                in_ext = inb_reg[1] && inb_reg[2];
            end
            default: begin
                axis   = ccf_pkg::AXIS_Y;
                in_ext = inb_reg[0] && inb_reg[2];
            end
        endcase
        contact = cfg.en && !sel[ccf_pkg::DIST_W-1] && in_ext;
        if (!contact) begin
            diff_next = '0;
        end else if (best == ccf_pkg::SIDE_NEAR || best == ccf_pkg::SIDE_RIGHT
                     || best == ccf_pkg::SIDE_TOP) begin
            diff_next = sel;
        end else begin
            diff_next = -sel;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg.app_x <= app_reg.app_x;
            out_reg.app_y <= app_reg.app_y;
            out_reg.app_z <= app_reg.app_z;
            out_reg.diff  <= diff_next;
            out_reg.axis  <= axis;
            out_reg.face  <= contact ? best : ccf_pkg::SIDE_NONE;
        end
    end

    assign out.valid = v4_reg;
    assign out.app_x = out_reg.app_x;
    assign out.app_y = out_reg.app_y;
    assign out.app_z = out_reg.app_z;
    assign out.diff  = out_reg.diff;
    assign out.axis  = out_reg.axis;
    assign out.face  = out_reg.face;

endmodule

// File: rtl/core/ccf_force.sv
// ----------------------------------------------------------------------------
// ccf_force
// Two-stage spring force: displacement times stiffness, then round,
// saturate and steer onto the contact axis.
// ----------------------------------------------------------------------------
module ccf_force (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              adv,
    input  ccf_pkg::face_item_t               in,
    input  logic [ccf_pkg::STIFF_W-1:0]       stiffness,
    output ccf_pkg::result_t                  out
);

    localparam logic signed [ccf_pkg::FPROD_W-1:0] HALF =
        ccf_pkg::FPROD_W'(1) <<< (ccf_pkg::FORCE_SH - 1);
    localparam logic signed [ccf_pkg::FPROD_W-1:0] F_MAX = ccf_pkg::FPROD_W'(8388607);
    localparam logic signed [ccf_pkg::FPROD_W-1:0] F_MIN = -ccf_pkg::FPROD_W'(8388608);

    ccf_pkg::face_item_t                 item_reg;
    logic signed [ccf_pkg::FPROD_W-1:0]  prod_reg;
    logic                                v5_reg;
    logic signed [ccf_pkg::FPROD_W-1:0]  shf;
    logic signed [ccf_pkg::FORCE_W-1:0]  mag;
    ccf_pkg::result_t                    res_reg;
    logic                                v6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (adv) begin
            v5_reg <= in.valid;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            item_reg <= in;
            prod_reg <= ccf_pkg::FPROD_W'(in.diff) * signed'(ccf_pkg::FPROD_W'(stiffness));
        end
    end

    always_comb begin
        shf = (prod_reg + HALF) >>> ccf_pkg::FORCE_SH;
        if (shf > F_MAX) begin
            mag = 24'sh7FFFFF;
        end else if (shf < F_MIN) begin
            mag = 24'sh800000;
        end else begin
            mag = signed'(shf[ccf_pkg::FORCE_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg.app_x   <= item_reg.app_x;
            res_reg.app_y   <= item_reg.app_y;
            res_reg.app_z   <= item_reg.app_z;
            res_reg.force_x <= (item_reg.axis == ccf_pkg::AXIS_X) ? mag : '0;
            res_reg.force_y <= (item_reg.axis == ccf_pkg::AXIS_Y) ? mag : '0;
            res_reg.force_z <= (item_reg.axis == ccf_pkg::AXIS_Z) ? mag : '0;
            res_reg.face    <= item_reg.face;
        end
    end

    assign out.valid   = v6_reg;
    assign out.app_x   = res_reg.app_x;
    assign out.app_y   = res_reg.app_y;
    assign out.app_z   = res_reg.app_z;
    assign out.force_x = res_reg.force_x;
    assign out.force_y = res_reg.force_y;
    assign out.force_z = res_reg.force_z;
    assign out.face    = res_reg.face;

endmodule

// File: rtl/core/cube_contact_force.sv
// An accepted request passes the affine, face and force stages to m_tvalid.
// Throughput: one request per cycle; the six-stage pipeline advances as a
// whole and holds while the output register waits on m_tready.
// Reset: aresetn clears all stage valid bits and loads the registers with
// zero rows, edge_length 256, stiffness 256 and enable off.
// ----------------------------------------------------------------------------
// cube_contact_force
// Haptic cube spring force: affine map of a tool position, nearest cube
// face search and stiffness-scaled contact force.
// ----------------------------------------------------------------------------
module cube_contact_force (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [ccf_pkg::ADDR_W-1:0]        cfg_addr,
    input  logic [ccf_pkg::ROW_W-1:0]         cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // dev_x[15:0], dev_y[31:16], dev_z[47:32]
    input  logic [ccf_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // app_x[15:0], app_y[31:16], app_z[47:32], force_x[71:48],
    // force_y[95:72], force_z[119:96], contact_face[122:120], zero[127:123]
    output logic [ccf_pkg::M_TDATA_W-1:0]     m_tdata
);

    ccf_pkg::cfg_t       cfg_reg;
    ccf_pkg::app_item_t  app_item;
    ccf_pkg::face_item_t face_item;
    ccf_pkg::result_t    res;
    logic                adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rows      <= '0;
            cfg_reg.edge_len  <= ccf_pkg::EDGE_LEN_RST;
            cfg_reg.stiffness <= ccf_pkg::STIFFNESS_RST;
            cfg_reg.en        <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                ccf_pkg::REG_ROW_X:     cfg_reg.rows[0]   <= cfg_wdata;
                ccf_pkg::REG_ROW_Y:     cfg_reg.rows[1]   <= cfg_wdata;
                ccf_pkg::REG_ROW_Z:     cfg_reg.rows[2]   <= cfg_wdata;
                ccf_pkg::REG_EDGE_LEN:  cfg_reg.edge_len  <= cfg_wdata[ccf_pkg::H_W-1:0];
                ccf_pkg::REG_STIFFNESS: cfg_reg.stiffness <= cfg_wdata[ccf_pkg::STIFF_W-1:0];
                ccf_pkg::REG_ENABLE:    cfg_reg.en        <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign adv      = !res.valid || m_tready;
    assign s_tready = adv;

    ccf_affine u_affine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (s_tvalid),
        .dev_x    (signed'(s_tdata[15:0])),
        .dev_y    (signed'(s_tdata[31:16])),
        .dev_z    (signed'(s_tdata[47:32])),
        .cfg      (cfg_reg),
        .out      (app_item)
    );

    ccf_face u_face (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in      (app_item),
        .cfg     (cfg_reg),
        .out     (face_item)
    );

    ccf_force u_force (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in        (face_item),
        .stiffness (cfg_reg.stiffness),
        .out       (res)
    );

    assign m_tvalid = res.valid;
    assign m_tdata  = {5'b0, res.face, res.force_z, res.force_y, res.force_x,
                       res.app_z, res.app_y, res.app_x};

    a_noface_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res.face == ccf_pkg::SIDE_NONE)
        |-> (res.force_x == '0 && res.force_y == '0 && res.force_z == '0))
        else $error("force without contact face");

    a_one_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($countones({res.force_x != '0, res.force_y != '0,
                                  res.force_z != '0}) <= 1))
        else $error("force on more than one axis");

    a_disabled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !cfg_reg.en) |-> (res.face == ccf_pkg::SIDE_NONE))
        else $error("contact reported while disabled");

    a_face_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res.face <= ccf_pkg::SIDE_NONE))
        else $error("contact face code out of range");

endmodule
